@@ src/rgb_pixel_blend_modes_macros.svh @@
// Assertion macros shared by the RGB blend block.
`ifndef RGB_PIXEL_BLEND_MODES_MACROS_SVH
`define RGB_PIXEL_BLEND_MODES_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define RPB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked on every rising clock edge outside reset.
`define RPB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ src/rpb_pkg.sv @@
// Package with the shared types and constants of the RGB blend block.
`default_nettype none

package rpb_pkg;

   localparam int CHAN_W     = 8;
   localparam int ALPHA_W    = 9;
   localparam int PROD_W     = 17;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int PIPE_STAGES = 4;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_MULTIPLY = 2'd1,
      MODE_SCREEN   = 2'd2,
      MODE_OVERLAY  = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MODE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ALPHA = 4'd1;

   // Settings seen by the datapath; alpha is already clamped to 0..256.
   typedef struct packed {
      mode_type           mode;
      logic [ALPHA_W-1:0] alpha;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/rgb_pixel_blend_modes.sv @@
// A transaction accepted at the input passes through the operand, product, sum and quotient registers to its result.
// Throughput: one pixel pair per clock outside reset; the four-stage channel pipeline never stalls.
// busy is high only during reset; start is then ignored.
// Reset (synchronous, active high) clears the pipeline valid bits and sets the
// mode to normal and alpha to 128; payload registers are not reset.
`default_nettype none

module rgb_pixel_blend_modes
   import rpb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel.
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [CHAN_W-1:0]     req_base_red,
   input  wire logic [CHAN_W-1:0]     req_base_green,
   input  wire logic [CHAN_W-1:0]     req_base_blue,
   input  wire logic [CHAN_W-1:0]     req_over_red,
   input  wire logic [CHAN_W-1:0]     req_over_green,
   input  wire logic [CHAN_W-1:0]     req_over_blue,
   // Result channel.
   output      logic                  rsp_strobe,
   output      logic [CHAN_W-1:0]     rsp_mix_red,
   output      logic [CHAN_W-1:0]     rsp_mix_green,
   output      logic [CHAN_W-1:0]     rsp_mix_blue,
   // Configuration channel.
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   `include "rgb_pixel_blend_modes_macros.svh"

   cfg_type cfg;
   logic    accept;

   // The pipeline advances on every clock, so the block is only busy while
   // reset holds the valid bits clear.
   assign busy   = reset;
   assign accept = start && !busy;

   // The configuration registers present the mode and the clamped alpha.
   rpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // One valid bit per pipeline stage travels alongside the channel data.
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[PIPE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe = valid_ff[PIPE_STAGES-1];

   // The three color channels are blended independently by identical pipelines.
   rpb_chan u_chan_red (
      .clock (clock),
      .cfg   (cfg),
      .base  (req_base_red),
      .over  (req_over_red),
      .mix   (rsp_mix_red)
   );

   rpb_chan u_chan_green (
      .clock (clock),
      .cfg   (cfg),
      .base  (req_base_green),
      .over  (req_over_green),
      .mix   (rsp_mix_green)
   );

   rpb_chan u_chan_blue (
      .clock (clock),
      .cfg   (cfg),
      .base  (req_base_blue),
      .over  (req_over_blue),
      .mix   (rsp_mix_blue)
   );

   // A result strobe must come from a transaction accepted at the pipeline input.
   `RPB_ASSERT(a_strobe_src, rsp_strobe |-> $past(accept, PIPE_STAGES), "orphan result strobe")

   // In multiply mode a white base pixel passes the overlay red channel through.
   `RPB_ASSERT_IMPL(a_mult_white, accept && cfg.mode == MODE_MULTIPLY && req_base_red == 8'd255, ##4 (rsp_mix_red == $past(req_over_red, 4)), "multiply by white failed")

   // A mode write lands in the configuration register on the next cycle.
   `RPB_ASSERT_IMPL(a_mode_write, csr_valid && csr_ready && csr_index == CSR_IDX_MODE, ##1 (cfg.mode == mode_type'($past(csr_data[1:0]))), "mode write lost")

endmodule

`default_nettype wire

@@ src/rpb_csr.sv @@
// Configuration registers of the RGB blend block.
`default_nettype none

module rpb_csr
   import rpb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output      cfg_type               cfg
);

   mode_type           mode_ff, mode_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_MODE:  mode_in  = mode_type'(csr_data[1:0]);
            CSR_IDX_ALPHA: alpha_in = csr_data[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         alpha_ff <= ALPHA_RESET;
      end else begin
         mode_ff  <= mode_in;
         alpha_ff <= alpha_in;
      end
   end

   // Any value with the top bit set is at least fully opaque.
   assign cfg.mode  = mode_ff;
   assign cfg.alpha = alpha_ff[ALPHA_W-1] ? ALPHA_ONE : alpha_ff;

endmodule

`default_nettype wire

@@ src/rpb_chan.sv @@
// Four-stage blend pipeline for one color channel.
`default_nettype none

module rpb_chan
   import rpb_pkg::*;
(
   input  wire logic              clock,
   input  wire cfg_type           cfg,
   input  wire logic [CHAN_W-1:0] base,
   input  wire logic [CHAN_W-1:0] over,
   output      logic [CHAN_W-1:0] mix
);

   typedef struct packed {
      logic norm;
      logic dbl;
      logic inv;
   } flag_type;

   // Stage 1: operand selection.
   logic [ALPHA_W-1:0] opa1_in, opa1_ff, opa2_in, opa2_ff;
   logic [CHAN_W-1:0]  opb1_in, opb1_ff, opb2_in, opb2_ff;
   flag_type           f1_in, f1_ff;

   always_comb begin
      opa1_in = {1'b0, base};
      opb1_in = over;
      opa2_in = '0;
      opb2_in = '0;
      f1_in   = '0;
      unique case (cfg.mode)
         MODE_NORMAL: begin
            opa1_in    = ALPHA_W'(10'd256 - {1'b0, cfg.alpha});
            opb1_in    = base;
            opa2_in    = cfg.alpha;
            opb2_in    = over;
            f1_in.norm = 1'b1;
         end
         MODE_MULTIPLY: begin
         end
         MODE_SCREEN: begin
            opa1_in   = {1'b0, ~base};
            opb1_in   = ~over;
            f1_in.inv = 1'b1;
         end
         MODE_OVERLAY: begin
            f1_in.dbl = 1'b1;
            if (base[CHAN_W-1]) begin
               opa1_in   = {1'b0, ~base};
               opb1_in   = ~over;
               f1_in.inv = 1'b1;
            end
         end
      endcase
   end

   // Stage 2: products.
   logic [PROD_W-1:0] m1_in, m1_ff, m2_in, m2_ff;
   flag_type          f2_ff;

   assign m1_in = opa1_ff * opb1_ff;
   assign m2_in = opa2_ff * opb2_ff;

   // Stage 3: sum for the alpha mix, the doubled product for overlay, else the product alone.
   logic [PROD_W-1:0] p_in, p_ff;
   flag_type          f3_ff;

   always_comb begin
      if (f2_ff.norm) begin
         p_in = m1_ff + m2_ff;
      end else if (f2_ff.dbl) begin
         p_in = {m1_ff[PROD_W-2:0], 1'b0};
      end else begin
         p_in = m1_ff;
      end
   end

   // Stage 4: the alpha mix takes the sum divided by 256; other modes divide by 255
   // from the shifted estimate with up to two corrections, then the optional complement.
   logic [ALPHA_W-1:0] q_est;
   logic [9:0]         rem;
   logic [ALPHA_W-1:0] quo;
   logic [CHAN_W-1:0]  mix_in, mix_ff;

   always_comb begin
      q_est = p_ff[PROD_W-1:8];
      rem   = {2'b00, p_ff[7:0]} + {1'b0, q_est};
      quo   = q_est + ALPHA_W'(rem >= 10'd255) + ALPHA_W'(rem >= 10'd510);
      if (f3_ff.norm) begin
         mix_in = p_ff[15:8];
      end else if (f3_ff.inv) begin
         mix_in = ~quo[CHAN_W-1:0];
      end else begin
         mix_in = quo[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      opa1_ff <= opa1_in;
      opb1_ff <= opb1_in;
      opa2_ff <= opa2_in;
      opb2_ff <= opb2_in;
      f1_ff   <= f1_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      f2_ff   <= f1_ff;
      p_ff    <= p_in;
      f3_ff   <= f2_ff;
      mix_ff  <= mix_in;
   end

   assign mix = mix_ff;

endmodule

`default_nettype wire
